// ===== rtl/emc_pkg.sv =====
// ----------------------------------------------------------------------------
// emc_pkg
// Shared types, constants and mask tables for the 3x3 edge magnitude core.
// ----------------------------------------------------------------------------
package emc_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;

    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int MODE_W = 2;
    localparam int WREG_W = 11;
    localparam int HREG_W = 13;
    localparam int ROW_W  = 13;
    localparam int CFG_W  = 13;
    localparam int IDX_W  = 2;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [CH_W-1:0]  t_chan;

    // operator select
    localparam logic [MODE_W-1:0] MODE_CDIFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SOBEL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ROBERTS = 2'd2;
    localparam logic [MODE_W-1:0] MODE_COMPASS = 2'd3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [MODE_W-1:0]  MODE_RST   = MODE_SOBEL;
    localparam logic [WREG_W-1:0]  WIDTH_RST  = 11'd640;
    localparam logic [HREG_W-1:0]  HEIGHT_RST = 13'd480;

    // x/10 == (x * 1639) >> 14 for 0 <= x <= 1275
    localparam logic [13:0] DIV10_MUL   = 14'd1639;
    localparam int          DIV10_SHIFT = 14;

    localparam logic signed [2:0] COMPASS [8][9] = '{
        '{ 3'sd1,  3'sd1,  3'sd1,  3'sd1, -3'sd2,  3'sd1, -3'sd1, -3'sd1, -3'sd1},
        '{ 3'sd1,  3'sd1,  3'sd1,  3'sd1, -3'sd2, -3'sd1,  3'sd1, -3'sd1, -3'sd1},
        '{ 3'sd1,  3'sd1, -3'sd1,  3'sd1, -3'sd2, -3'sd1,  3'sd1,  3'sd1, -3'sd1},
        '{ 3'sd1, -3'sd1, -3'sd1,  3'sd1, -3'sd2, -3'sd1,  3'sd1,  3'sd1,  3'sd1},
        '{-3'sd1, -3'sd1, -3'sd1,  3'sd1, -3'sd2,  3'sd1,  3'sd1,  3'sd1,  3'sd1},
        '{-3'sd1, -3'sd1,  3'sd1, -3'sd1, -3'sd2,  3'sd1,  3'sd1,  3'sd1,  3'sd1},
        '{-3'sd1,  3'sd1,  3'sd1, -3'sd1, -3'sd2,  3'sd1, -3'sd1,  3'sd1,  3'sd1},
        '{ 3'sd1,  3'sd1,  3'sd1, -3'sd1, -3'sd2,  3'sd1, -3'sd1, -3'sd1,  3'sd1}
    };

endpackage

// ===== rtl/emc_line_store.sv =====
// ----------------------------------------------------------------------------
// emc_line_store
// Two line memories (upper and lower row), one read and one write port each,
// registered read data.
// ----------------------------------------------------------------------------
module emc_line_store #(
    parameter int DEPTH = emc_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  emc_pkg::t_pix       i_wdata_up,
    input  emc_pkg::t_pix       i_wdata_lo,
    output emc_pkg::t_pix       o_rdata_up,
    output emc_pkg::t_pix       o_rdata_lo
);

    emc_pkg::t_pix mem_up [DEPTH];
    emc_pkg::t_pix mem_lo [DEPTH];
    emc_pkg::t_pix r_rd_up;
    emc_pkg::t_pix r_rd_lo;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_up[i_waddr] <= i_wdata_up;
            mem_lo[i_waddr] <= i_wdata_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_up <= mem_up[i_raddr];
            r_rd_lo <= mem_lo[i_raddr];
        end
    end

    assign o_rdata_up = r_rd_up;
    assign o_rdata_lo = r_rd_lo;

endmodule

// ===== rtl/emc_chan.sv =====
// ----------------------------------------------------------------------------
// emc_chan
// Edge operator for one color channel: gradients, squares, bit-serial
// square root and final scaling. Runs C_GRAD, C_SQ, C_ROOT and C_FIN in turn from start to done.
// ----------------------------------------------------------------------------
module emc_chan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [emc_pkg::MODE_W-1:0]   i_mode,
    input  emc_pkg::t_chan               i_p [9],
    output logic                         o_done,
    output emc_pkg::t_chan               o_res
);

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_GRAD = 3'd1;
    localparam logic [2:0] C_SQ   = 3'd2;
    localparam logic [2:0] C_ROOT = 3'd3;
    localparam logic [2:0] C_FIN  = 3'd4;

    logic [2:0]                     r_state;
    logic                           r_done;
    logic [emc_pkg::MODE_W-1:0]     r_mode;
    emc_pkg::t_chan                 r_p [9];
    logic signed [10:0]             r_gx, r_gy;
    logic [7:0]                     r_rob;
    logic signed [11:0]             r_sum [8];
    logic [10:0]                    r_best;
    logic [20:0]                    r_v, r_root, r_bit;
    emc_pkg::t_chan                 r_res;

    logic signed [10:0]             n_gx, n_gy;
    logic [7:0]                     n_rob;
    logic signed [11:0]             n_sum [8];
    logic signed [11:0]             n_max;
    logic signed [21:0]             sq_x, sq_y;
    logic [21:0]                    trial;
    logic [24:0]                    div_prod;
    logic [10:0]                    root_div;

    function automatic logic signed [10:0] ext11(input emc_pkg::t_chan v);
        ext11 = signed'({3'b000, v});
    endfunction

    function automatic logic [7:0] absdiff(input emc_pkg::t_chan a, input emc_pkg::t_chan b);
        absdiff = (a >= b) ? (a - b) : (b - a);
    endfunction

    // gradients, Roberts and compass responses
    always_comb begin
        logic signed [11:0] s;
        logic signed [11:0] pe;
        logic [7:0]         ra, rb;
        if (r_mode == emc_pkg::MODE_CDIFF) begin
            n_gx = ext11(r_p[3]) - ext11(r_p[5]);
            n_gy = ext11(r_p[1]) - ext11(r_p[7]);
        end else begin
            n_gx = ext11(r_p[0]) - ext11(r_p[2]) + (ext11(r_p[3]) <<< 1)
                 - (ext11(r_p[5]) <<< 1) + ext11(r_p[6]) - ext11(r_p[8]);
            n_gy = ext11(r_p[0]) + (ext11(r_p[1]) <<< 1) + ext11(r_p[2])
                 - ext11(r_p[6]) - (ext11(r_p[7]) <<< 1) - ext11(r_p[8]);
        end
        ra    = absdiff(r_p[4], r_p[8]);
        rb    = absdiff(r_p[5], r_p[7]);
        n_rob = (ra > rb) ? ra : rb;
        for (int k = 0; k < 8; k++) begin
            s = '0;
            for (int i = 0; i < 9; i++) begin
                pe = signed'({4'b0000, r_p[i]});
                if (emc_pkg::COMPASS[k][i] == 3'sd1) begin
                    s = s + pe;
                end else if (emc_pkg::COMPASS[k][i] == -3'sd1) begin
                    s = s - pe;
                end else begin
                    s = s - (pe <<< 1);
                end
            end
            n_sum[k] = s;
        end
    end

    always_comb begin
        n_max = r_sum[0];
        for (int k = 1; k < 8; k++) begin
            if (r_sum[k] > n_max) begin
                n_max = r_sum[k];
            end
        end
        if (n_max < 0) begin
            n_max = '0;
        end
    end

    assign sq_x     = r_gx * r_gx;
    assign sq_y     = r_gy * r_gy;
    assign trial    = {1'b0, r_root} + {1'b0, r_bit};
    assign div_prod = r_best * emc_pkg::DIV10_MUL;
    assign root_div = (r_mode == emc_pkg::MODE_CDIFF) ? (r_root[10:0] >> 1)
                                                      : (r_root[10:0] >> 3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_state <= C_GRAD;
                        r_done  <= 1'b0;
                    end
                end
                C_GRAD:  r_state <= C_SQ;
                C_SQ:    r_state <= C_ROOT;
                C_ROOT: begin
                    if (r_bit == 21'd1) begin
                        r_state <= C_FIN;
                    end
                end
                C_FIN: begin
                    r_state <= C_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_start) begin
            r_p    <= i_p;
            r_mode <= i_mode;
        end
        if (r_state == C_GRAD) begin
            r_gx  <= n_gx;
            r_gy  <= n_gy;
            r_rob <= n_rob;
            r_sum <= n_sum;
        end
        if (r_state == C_SQ) begin
            r_v    <= 21'(unsigned'(sq_x + sq_y));
            r_best <= 11'(n_max);
            r_root <= '0;
            r_bit  <= 21'd1 << 20;
        end
        if (r_state == C_ROOT) begin
            if ({1'b0, r_v} >= trial) begin
                r_v    <= 21'({1'b0, r_v} - trial);
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (r_state == C_FIN) begin
            unique case (r_mode)
                emc_pkg::MODE_CDIFF, emc_pkg::MODE_SOBEL:
                    r_res <= (root_div > 11'd255) ? 8'hFF : root_div[7:0];
                emc_pkg::MODE_ROBERTS:
                    r_res <= r_rob;
                default:
                    r_res <= 8'(div_prod >> emc_pkg::DIV10_SHIFT);
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/edge_magnitude_3x3_core.sv =====
// ----------------------------------------------------------------------------
// edge_magnitude_3x3_core
// Per-channel 3x3 edge magnitude over an RGB raster with two line stores.
// Flow: accept, line store read, window update in S_READ, channel units incl. an
//   11-step square root in S_CALC, output register.
// A new pixel is taken only in S_IDLE, once the previous one is finished; one
//   that yields no result returns there from S_READ; a stray flush is dropped.
// Reset: synchronous active low; clears counters, window, registers to their
//   defaults. Line stores are not cleared.
// ----------------------------------------------------------------------------
module edge_magnitude_3x3_core #(
    parameter int MAX_WIDTH = emc_pkg::MAX_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [23:0]                 i_s_tdata,   // red_in, green_in, blue_in
    input  logic                        i_s_tuser,   // kind
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [23:0]                 o_m_tdata,   // red_out, green_out, blue_out
    output logic                        o_m_tlast,   // end_of_line
    output logic                        o_m_tuser,   // end_of_frame
    input  logic                        i_cfg_we,
    input  logic [emc_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [emc_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = emc_pkg::ROW_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;

    logic [1:0]                     r_state;
    logic [emc_pkg::MODE_W-1:0]     r_mode;
    logic [emc_pkg::WREG_W-1:0]     r_width;
    logic [emc_pkg::HREG_W-1:0]     r_height;
    logic [CW-1:0]                  r_col, r_colx;
    logic [RW-1:0]                  r_row, r_rowx;
    emc_pkg::t_pix                  r_window [9];
    emc_pkg::t_pix                  r_cur;
    logic                           r_eol, r_eof;
    logic                           r_out_valid;
    logic [23:0]                    r_out_data;
    logic                           r_out_last, r_out_user;

    logic [WW-1:0]                  eff_w;
    logic [RW-1:0]                  eff_h;
    logic [CW-1:0]                  col_in;
    logic                           drain;
    logic                           accept;
    emc_pkg::t_pix                  rd_up, rd_lo;
    emc_pkg::t_pix                  n_window [9];
    emc_pkg::t_pix                  taps [9];
    logic                           right_edge, emit, frame_done;
    logic [RW-1:0]                  cy;
    logic [1:0]                     rs [3];
    logic [1:0]                     cs [3];
    logic [CW-1:0]                  n_col;
    logic [RW-1:0]                  n_row;
    logic                           chan_start;
    logic [2:0]                     chan_done;
    emc_pkg::t_chan                 chan_p [3][9];
    emc_pkg::t_chan                 chan_res [3];
    logic                           out_free;

    // effective geometry
    always_comb begin
        if (r_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_width);
        end
        if (r_height == '0) begin
            eff_h = RW'(1);
        end else if (32'(r_height) > 32'(emc_pkg::MAX_HEIGHT)) begin
            eff_h = RW'(emc_pkg::MAX_HEIGHT);
        end else begin
            eff_h = RW'(r_height);
        end
    end

    assign col_in     = (32'(r_col) >= 32'(eff_w)) ? '0 : r_col;
    assign drain      = (r_row >= eff_h);
    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    emc_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_store (
        .i_clk      (i_clk),
        .i_re       (accept),
        .i_raddr    (col_in),
        .i_we       (r_state == S_READ),
        .i_waddr    (r_colx),
        .i_wdata_up (rd_lo),
        .i_wdata_lo (r_cur),
        .o_rdata_up (rd_up),
        .o_rdata_lo (rd_lo)
    );

    // window shift and neighborhood selection
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_window[r*3]     = r_window[r*3+1];
            n_window[r*3+1]   = r_window[r*3+2];
        end
        n_window[2] = rd_up;
        n_window[5] = rd_lo;
        n_window[8] = r_cur;

        right_edge = (r_colx == '0) && (r_rowx >= RW'(2));
        emit       = right_edge || ((r_colx != '0) && (r_rowx != '0));
        cy         = right_edge ? (r_rowx - RW'(2)) : (r_rowx - RW'(1));
        frame_done = right_edge && (cy == eff_h - RW'(1));

        rs[0] = (cy == '0) ? 2'd1 : 2'd0;
        rs[1] = 2'd1;
        rs[2] = (cy == eff_h - RW'(1)) ? 2'd1 : 2'd2;
        if (right_edge) begin
            cs[0] = (eff_w >= WW'(2)) ? 2'd1 : 2'd2;
            cs[1] = 2'd2;
        end else begin
            cs[0] = (r_colx == CW'(1)) ? 2'd1 : 2'd0;
            cs[1] = 2'd1;
        end
        cs[2] = 2'd2;

        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                taps[i*3+j] = right_edge ?
                    r_window[4'({2'b00, rs[i]} * 4'd3 + {2'b00, cs[j]})] :
                    n_window[4'({2'b00, rs[i]} * 4'd3 + {2'b00, cs[j]})];
            end
        end
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 9; k++) begin
                chan_p[c][k] = taps[k][8*c +: 8];
            end
        end

        if (32'(r_colx) + 1 >= 32'(eff_w)) begin
            n_col = '0;
            n_row = r_rowx + RW'(1);
        end else begin
            n_col = r_colx + CW'(1);
            n_row = r_rowx;
        end
    end

    assign chan_start = (r_state == S_READ) && emit;

    for (genvar c = 0; c < 3; c++) begin : g_chan
        emc_chan u_chan (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (chan_start),
            .i_mode  (r_mode),
            .i_p     (chan_p[c]),
            .o_done  (chan_done[c]),
            .o_res   (chan_res[c])
        );
    end

    // control, configuration, counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= emc_pkg::MODE_RST;
            r_width  <= emc_pkg::WIDTH_RST;
            r_height <= emc_pkg::HEIGHT_RST;
            r_col    <= '0;
            r_row    <= '0;
            for (int k = 0; k < 9; k++) begin
                r_window[k] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    emc_pkg::REG_MODE: r_mode <= i_cfg_data[emc_pkg::MODE_W-1:0];
                    emc_pkg::REG_WIDTH: begin
                        r_width <= i_cfg_data[emc_pkg::WREG_W-1:0];
                        r_col   <= '0;
                        r_row   <= '0;
                    end
                    emc_pkg::REG_HEIGHT: begin
                        r_height <= i_cfg_data[emc_pkg::HREG_W-1:0];
                        r_col    <= '0;
                        r_row    <= '0;
                    end
                    default: ;
                endcase
            end

            if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    // a flush before the frame is complete is dropped
                    if (accept && (drain || !i_s_tuser)) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_window <= n_window;
                    if (frame_done) begin
                        r_col <= '0;
                        r_row <= '0;
                    end else begin
                        r_col <= n_col;
                        r_row <= n_row;
                    end
                    r_state <= emit ? S_CALC : S_IDLE;
                end
                S_CALC: begin
                    if ((&chan_done) && out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur  <= drain ? '0 : i_s_tdata;
            r_colx <= col_in;
            r_rowx <= r_row;
        end
        if (r_state == S_READ) begin
            r_eol <= right_edge;
            r_eof <= frame_done;
        end
        if (r_state == S_CALC && (&chan_done) && out_free) begin
            r_out_data <= {chan_res[2], chan_res[1], chan_res[0]};
            r_out_last <= r_eol;
            r_out_user <= r_eof;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_user;

endmodule

// ===== rtl/emc_checker.sv =====
// ----------------------------------------------------------------------------
// emc_checker
// Port-level checks for the edge magnitude core, bound to the top level.
// ----------------------------------------------------------------------------
module emc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_tvalid,
    input logic                         o_s_tready,
    input logic                         i_s_tuser,
    input logic                         o_m_tvalid,
    input logic                         i_m_tready,
    input logic [23:0]                  o_m_tdata,
    input logic                         o_m_tlast,
    input logic                         o_m_tuser
);

    // stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("output changed while stalled");

    // end of frame only on the last pixel of a line
    a_eof_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("end of frame without end of line");

    // a pixel transaction always occupies the datapath for the next cycle
    a_busy_after_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !i_s_tuser |=> !o_s_tready)
        else $error("ready right after pixel transaction");

    // nothing pending out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind edge_magnitude_3x3_core emc_checker u_emc_checker (.*);
